// ===== hw/rtl/nrmc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types and constants for the nearest-time GNRMC fix finder
// Record layout between the line parser and the fix selector, character
// codes, fixed-point scale factors and output limits.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  localparam int TimeBits      = 48;
  localparam int CfgBits       = 48;
  localparam int CfgIdxBits    = 1;
  localparam int MinFracDigits = 5;
  localparam int QueueDepth    = 4;

  // decimal powers, used for sizing and for minute scaling
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] r;
    unique case (n)
      0:       r = 64'd1;
      1:       r = 64'd10;
      2:       r = 64'd100;
      3:       r = 64'd1000;
      4:       r = 64'd10000;
      5:       r = 64'd100000;
      6:       r = 64'd1000000;
      7:       r = 64'd10000000;
      8:       r = 64'd100000000;
      9:       r = 64'd1000000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

  localparam int MinBits    = $clog2(pow10(MinFracDigits + 2));
  localparam int FracBits   = $clog2(MinFracDigits + 1);
  localparam int LatDegBits = 7;
  localparam int LonDegBits = 10;
  localparam int LatDegLen  = 2;
  localparam int LonDegLen  = 3;

  // degree conversion: e7 part of the minutes is (m * 10^(7-frac) + 30) / 60
  localparam int  ScaleBits  = 24;
  localparam int  ProdBits   = 30;
  localparam int  RecipBits  = 31;
  localparam int  RecipShift = 36;
  localparam logic [RecipBits-1:0] Recip60 = RecipBits'(((64'd1 << RecipShift) + 64'd59) / 64'd60);
  localparam int  PartBits   = ProdBits + RecipBits - RecipShift;
  localparam int  E7Bits     = 34;
  localparam logic [E7Bits-1:0] DegScale = E7Bits'(10000000);
  localparam logic [E7Bits-1:0] LatLimit = E7Bits'(900000000);
  localparam logic [E7Bits-1:0] LonLimit = E7Bits'(1800000000);
  localparam logic [31:0]       NotFoundE7 = 32'hFF67_6980;  // -10000000

  // characters
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChVt      = 8'd11;
  localparam logic [7:0] ChFf      = 8'd12;
  localparam logic [7:0] ChCr      = 8'd13;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChS       = 8'h53;
  localparam logic [7:0] ChW       = 8'h57;

  localparam int TagLen     = 6;
  localparam int TagIdxBits = 3;
  localparam logic [7:0] TagText [TagLen] = '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43};

  // comma field numbers
  localparam logic [3:0] FieldLat = 4'd3;
  localparam logic [3:0] FieldNs  = 4'd4;
  localparam logic [3:0] FieldLon = 4'd5;
  localparam logic [3:0] FieldEw  = 4'd6;
  localparam logic [3:0] FieldMax = 4'd15;

  typedef enum logic [1:0] {
    NUM_BLANK,
    NUM_SIGN,
    NUM_DIGITS,
    NUM_DONE
  } num_state_e;

  typedef enum logic [1:0] {
    REC_TIME,
    REC_FIX,
    REC_SKIP
  } rec_kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_QUERY_TIME   = 1'b0,
    CFG_MATCH_WINDOW = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [LonDegBits-1:0] deg;
    logic [MinBits-1:0]    minutes;
    logic [FracBits-1:0]   frac;
    logic                  neg;
  } coord_t;

  typedef struct packed {
    coord_t lat;
    coord_t lon;
  } fix_t;

  // one closed line
  typedef struct packed {
    logic                is_last;
    rec_kind_e           kind;
    logic [TimeBits-1:0] time_us;
    fix_t                fix;
  } rec_t;

  // scan outcome handed to the degree converter
  typedef struct packed {
    logic found;
    fix_t fix;
  } verdict_t;

endpackage

// ===== hw/rtl/nrmc_front.sv =====
// ----------------------------------------------------------------------------
// nrmc_front: byte-level line parser
// Tracks tag match, timestamp digits and GNRMC coordinate fields per byte and
// emits one record each time a line closes.
// ----------------------------------------------------------------------------
module nrmc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     text_byte_i,
  input  logic           end_of_log_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           q_full_i,
  output logic           push_o,
  output nrmc_pkg::rec_t rec_o
);
  import nrmc_pkg::*;

  localparam int WideBits = TimeBits + 4;

  typedef struct packed {
    logic [TagIdxBits-1:0] tag;
    logic                  sent;
    logic [3:0]            field;
    logic [3:0]            chars;
    logic [FracBits-1:0]   frac;
    logic [1:0]            mint;
    logic                  dot;
    num_state_e            nst;
    logic [TimeBits-1:0]   time_us;
    logic [LatDegBits-1:0] lat_deg;
    logic [MinBits-1:0]    lat_min;
    logic [FracBits-1:0]   lat_frac;
    logic                  south;
    logic [LonDegBits-1:0] lon_deg;
    logic [MinBits-1:0]    lon_min;
    logic [FracBits-1:0]   lon_frac;
    logic                  west;
    logic                  ok;
  } line_t;

  typedef struct packed {
    logic [LonDegBits-1:0] deg;
    logic [MinBits-1:0]    minutes;
    logic [1:0]            mint;
    logic [FracBits-1:0]   frac;
    logic                  dot;
    logic                  bad;
  } cst_t;

  localparam line_t LineClear = '{ok: 1'b1, nst: NUM_BLANK, default: '0};

  line_t line_q, line_d, tk, sel;
  cst_t  cs, cr;
  logic  dig, is_nl, closing, fire, fin_ok;
  logic [3:0] dval;
  logic [WideBits-1:0] tw;

  // coordinate field ended without full degrees or any minute digit
  function automatic logic coord_short(logic [3:0] chars, int unsigned deg_len,
                                       logic [1:0] mint, logic [FracBits-1:0] frac);
    return (chars < 4'(deg_len)) || (mint == 2'd0 && frac == '0);
  endfunction

  function automatic cst_t coord_char(cst_t s, logic [7:0] c, logic [3:0] chars,
                                      int unsigned deg_len);
    cst_t r;
    logic dg;
    r     = s;
    r.bad = 1'b0;
    dg    = (c >= ChZero) && (c <= ChNine);
    if (chars < 4'(deg_len)) begin
      if (dg) r.deg = LonDegBits'(s.deg * LonDegBits'(10) + LonDegBits'(c[3:0]));
      else    r.bad = 1'b1;
    end else if (dg) begin
      if (!s.dot) begin
        if (s.mint == 2'd2) begin
          r.bad = 1'b1;
        end else begin
          r.mint    = s.mint + 2'd1;
          r.minutes = MinBits'(s.minutes * MinBits'(10) + MinBits'(c[3:0]));
        end
      end else if (s.frac < FracBits'(MinFracDigits)) begin
        // digits past the kept precision are dropped
        r.frac    = s.frac + FracBits'(1);
        r.minutes = MinBits'(s.minutes * MinBits'(10) + MinBits'(c[3:0]));
      end
    end else if (c == ChDot && !s.dot) begin
      r.dot = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    dig  = (text_byte_i >= ChZero) && (text_byte_i <= ChNine);
    dval = text_byte_i[3:0];
    tw   = WideBits'({line_q.time_us, 3'b000}) + WideBits'({line_q.time_us, 1'b0})
         + WideBits'(dval);
    tk   = line_q;
    cs   = '0;
    cr   = '0;

    // tag search
    if (line_q.tag < TagIdxBits'(TagLen)) begin
      if (text_byte_i == TagText[line_q.tag]) tk.tag = line_q.tag + TagIdxBits'(1);
      else if (text_byte_i == ChDollar)       tk.tag = TagIdxBits'(1);
      else                                     tk.tag = '0;
      if (tk.tag == TagIdxBits'(TagLen)) tk.sent = 1'b1;
    end

    // leading integer of a timestamp line
    unique case (line_q.nst)
      NUM_BLANK, NUM_SIGN: begin
        if (line_q.nst == NUM_BLANK && (text_byte_i == ChSpace || text_byte_i == ChTab ||
            text_byte_i == ChVt || text_byte_i == ChFf || text_byte_i == ChCr)) begin
          tk.nst = NUM_BLANK;
        end else if (line_q.nst == NUM_BLANK && text_byte_i == ChPlus) begin
          tk.nst = NUM_SIGN;
        end else if (dig) begin
          tk.time_us = TimeBits'(dval);
          tk.nst     = NUM_DIGITS;
        end else begin
          tk.time_us = '0;
          tk.nst     = NUM_DONE;
        end
      end
      NUM_DIGITS: begin
        if (dig) begin
          if (tw[WideBits-1:TimeBits] != '0) tk.time_us = '1;
          else                               tk.time_us = tw[TimeBits-1:0];
        end else begin
          tk.nst = NUM_DONE;
        end
      end
      NUM_DONE: tk.nst = NUM_DONE;
      default:  tk.nst = NUM_DONE;
    endcase

    // comma fields
    if (text_byte_i == ChComma) begin
      if (line_q.field == FieldLat &&
          coord_short(line_q.chars, LatDegLen, line_q.mint, line_q.frac)) tk.ok = 1'b0;
      if (line_q.field == FieldLon &&
          coord_short(line_q.chars, LonDegLen, line_q.mint, line_q.frac)) tk.ok = 1'b0;
      if (line_q.field == FieldLat) tk.lat_frac = line_q.frac;
      if (line_q.field == FieldLon) tk.lon_frac = line_q.frac;
      if (line_q.field != FieldMax) tk.field = line_q.field + 4'd1;
      tk.chars = '0;
      tk.frac  = '0;
      tk.mint  = '0;
      tk.dot   = 1'b0;
    end else begin
      if (line_q.field == FieldLat) begin
        cs = '{deg: LonDegBits'(line_q.lat_deg), minutes: line_q.lat_min, mint: line_q.mint,
               frac: line_q.frac, dot: line_q.dot, bad: 1'b0};
        cr = coord_char(cs, text_byte_i, line_q.chars, LatDegLen);
        tk.lat_deg = cr.deg[LatDegBits-1:0];
        tk.lat_min = cr.minutes;
        tk.mint    = cr.mint;
        tk.frac    = cr.frac;
        tk.dot     = cr.dot;
        if (cr.bad) tk.ok = 1'b0;
      end else if (line_q.field == FieldLon) begin
        cs = '{deg: line_q.lon_deg, minutes: line_q.lon_min, mint: line_q.mint,
               frac: line_q.frac, dot: line_q.dot, bad: 1'b0};
        cr = coord_char(cs, text_byte_i, line_q.chars, LonDegLen);
        tk.lon_deg = cr.deg;
        tk.lon_min = cr.minutes;
        tk.mint    = cr.mint;
        tk.frac    = cr.frac;
        tk.dot     = cr.dot;
        if (cr.bad) tk.ok = 1'b0;
      end else if (line_q.field == FieldNs) begin
        tk.south = (line_q.chars == 4'd0) && (text_byte_i == ChS);
      end else if (line_q.field == FieldEw) begin
        tk.west = (line_q.chars == 4'd0) && (text_byte_i == ChW);
      end
      if (line_q.chars != FieldMax) tk.chars = line_q.chars + 4'd1;
    end

    // a newline closes the line as it stands, a final byte closes after it is taken
    is_nl   = (text_byte_i == ChNewline);
    closing = is_nl || end_of_log_i;
    sel     = is_nl ? line_q : tk;
    fin_ok  = sel.ok && (sel.field >= FieldEw)
            && !(sel.field == FieldLat && coord_short(sel.chars, LatDegLen, sel.mint, sel.frac))
            && !(sel.field == FieldLon && coord_short(sel.chars, LonDegLen, sel.mint, sel.frac));

    rec_o.is_last         = end_of_log_i;
    rec_o.kind            = sel.sent ? (fin_ok ? REC_FIX : REC_SKIP) : REC_TIME;
    rec_o.time_us         = sel.time_us;
    rec_o.fix.lat.deg     = LonDegBits'(sel.lat_deg);
    rec_o.fix.lat.minutes = sel.lat_min;
    // fraction counts were latched as each coordinate field closed
    rec_o.fix.lat.frac    = sel.lat_frac;
    rec_o.fix.lat.neg     = sel.south;
    rec_o.fix.lon.deg     = sel.lon_deg;
    rec_o.fix.lon.minutes = sel.lon_min;
    rec_o.fix.lon.frac    = sel.lon_frac;
    rec_o.fix.lon.neg     = sel.west;

    in_stall_o = q_full_i;
    fire       = in_valid_i && !in_stall_o;
    push_o     = fire && closing;

    line_d = line_q;
    if (fire) line_d = closing ? LineClear : tk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LineClear;
    end else begin
      line_q <= line_d;
    end
  end

endmodule

// ===== hw/rtl/nrmc_queue.sv =====
// ----------------------------------------------------------------------------
// nrmc_queue: line record queue
// Small first-in first-out buffer between the parser and the fix selector.
// ----------------------------------------------------------------------------
module nrmc_queue #(
  parameter int unsigned DEPTH = nrmc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nrmc_pkg::rec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output nrmc_pkg::rec_t rec_o
);
  import nrmc_pkg::*;

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  rec_t               mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  always_comb begin
    valid_o  = (count_q != '0);
    full_o   = (count_q == CntBits'(DEPTH));
    rec_o    = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (push_i && !pop_i)      count_d = count_q + CntBits'(1);
    else if (pop_i && !push_i) count_d = count_q - CntBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

endmodule

// ===== hw/rtl/nrmc_back.sv =====
// ----------------------------------------------------------------------------
// nrmc_back: fix selector
// Applies line records in order: timestamp lines set the current time, valid
// sentences compete on distance to the query, the final record ends the scan.
// ----------------------------------------------------------------------------
module nrmc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nrmc_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [nrmc_pkg::CfgBits-1:0]  cfg_wdata_i,
  input  logic                          rec_valid_i,
  input  nrmc_pkg::rec_t                rec_i,
  output logic                          pop_o,
  output logic                          vd_valid_o,
  output nrmc_pkg::verdict_t            vd_o,
  input  logic                          vd_ready_i
);
  import nrmc_pkg::*;

  logic [CfgBits-1:0]  query_q, window_q;
  logic [TimeBits-1:0] query_t, prev_q, prev_d, cand_diff;
  logic                cand_inwin;

  // selector stage
  logic                b_valid_q, b_valid_d;
  logic                b_last_q, b_fix_q, b_inwin_q;
  logic [TimeBits-1:0] b_diff_q;
  fix_t                b_coord_q;
  logic                b_ready, b_fire, win;

  // best fix so far
  logic                best_valid_q, best_valid_d;
  logic [TimeBits-1:0] best_diff_q, best_diff_d;
  logic                best_inwin_q;
  fix_t                best_fix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q  <= '0;
      window_q <= CfgBits'(1000000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_QUERY_TIME:   query_q  <= cfg_wdata_i;
        CFG_MATCH_WINDOW: window_q <= cfg_wdata_i;
        default:          query_q  <= query_q;
      endcase
    end
  end

  always_comb begin
    query_t    = query_q[TimeBits-1:0];
    cand_diff  = (prev_q >= query_t) ? (prev_q - query_t) : (query_t - prev_q);
    cand_inwin = (CfgBits'(cand_diff) <= window_q);

    b_ready = !b_valid_q || !b_last_q || vd_ready_i;
    pop_o   = rec_valid_i && b_ready;
    b_fire  = b_valid_q && b_ready;

    b_valid_d = b_ready ? pop_o : b_valid_q;

    prev_d = prev_q;
    if (pop_o) begin
      if (rec_i.kind == REC_TIME) prev_d = rec_i.time_us;
      if (rec_i.is_last)          prev_d = '0;
    end

    // strict compare keeps the earliest fix on a tie
    win = b_fix_q && (!best_valid_q || (b_diff_q < best_diff_q));

    best_valid_d = best_valid_q;
    best_diff_d  = best_diff_q;
    if (b_fire) begin
      if (win) begin
        best_valid_d = 1'b1;
        best_diff_d  = b_diff_q;
      end
      if (b_last_q) begin
        best_valid_d = 1'b0;
        best_diff_d  = '1;
      end
    end

    vd_valid_o = b_valid_q && b_last_q;
    vd_o.found = win ? b_inwin_q : (best_valid_q && best_inwin_q);
    vd_o.fix   = win ? b_coord_q : best_fix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      b_valid_q    <= 1'b0;
      best_valid_q <= 1'b0;
      best_diff_q  <= '1;
    end else begin
      prev_q       <= prev_d;
      b_valid_q    <= b_valid_d;
      best_valid_q <= best_valid_d;
      best_diff_q  <= best_diff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_last_q  <= rec_i.is_last;
      b_fix_q   <= (rec_i.kind == REC_FIX);
      b_diff_q  <= cand_diff;
      b_inwin_q <= cand_inwin;
      b_coord_q <= rec_i.fix;
    end
    if (b_fire && win) begin
      best_inwin_q <= b_inwin_q;
      best_fix_q   <= b_coord_q;
    end
  end

endmodule

// ===== hw/rtl/nrmc_convert.sv =====
// ----------------------------------------------------------------------------
// nrmc_convert: degree converter
// Turns degrees and scaled minutes into 1e-7 degree units with round to
// nearest, saturation and hemisphere sign, in four stages.
// ----------------------------------------------------------------------------
module nrmc_convert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vd_valid_i,
  input  nrmc_pkg::verdict_t vd_i,
  output logic               vd_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o
);
  import nrmc_pkg::*;

  logic en;
  coord_t lane [2];

  logic                        v1_q, v2_q, v3_q, out_valid_q;
  logic                        f1_q, f2_q, f3_q;
  logic                        neg1_q [2], neg2_q [2], neg3_q [2];
  logic [ProdBits-1:0]         x1_q [2];
  logic [E7Bits-1:0]           dp1_q [2], dp2_q [2], mag3_q [2];
  logic [PartBits-1:0]         part2_q [2];
  logic [MinBits+ScaleBits-1:0] scaled [2];
  logic [ScaleBits-1:0]        scale [2];
  logic [ProdBits+RecipBits-1:0] recip [2];
  logic [E7Bits-1:0]           lim [2], sat [2], sval [2];
  logic                        found_q;
  logic [30:0]                 lat_q;
  logic [31:0]                 lon_q;

  always_comb begin
    en         = !(out_valid_q && out_stall_i);
    vd_ready_o = en;
    lane[0]    = vd_i.fix.lat;
    lane[1]    = vd_i.fix.lon;
    lim[0]     = LatLimit;
    lim[1]     = LonLimit;
    for (int i = 0; i < 2; i++) begin
      scale[i]  = ScaleBits'(pow10(32'd7 - 32'(lane[i].frac)));
      scaled[i] = lane[i].minutes * scale[i];
      // divide by 60 through a reciprocal, exact for all 30 bit inputs
      recip[i]  = x1_q[i] * Recip60;
      sat[i]    = (mag3_q[i] > lim[i]) ? lim[i] : mag3_q[i];
      sval[i]   = neg3_q[i] ? (~sat[i] + E7Bits'(1)) : sat[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= vd_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q    <= vd_i.found;
      f2_q    <= f1_q;
      f3_q    <= f2_q;
      found_q <= f3_q;
      for (int i = 0; i < 2; i++) begin
        x1_q[i]    <= ProdBits'(scaled[i]) + ProdBits'(30);
        dp1_q[i]   <= E7Bits'(lane[i].deg) * DegScale;
        neg1_q[i]  <= lane[i].neg;
        part2_q[i] <= recip[i][ProdBits+RecipBits-1:RecipShift];
        dp2_q[i]   <= dp1_q[i];
        neg2_q[i]  <= neg1_q[i];
        mag3_q[i]  <= dp2_q[i] + E7Bits'(part2_q[i]);
        neg3_q[i]  <= neg2_q[i];
      end
      lat_q <= f3_q ? sval[0][30:0] : NotFoundE7[30:0];
      lon_q <= f3_q ? sval[1][31:0] : NotFoundE7;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign latitude_e7_o  = $signed(lat_q);
  assign longitude_e7_o = $signed(lon_q);

endmodule

// ===== hw/rtl/nmea_rmc_nearest_time_fix_core.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_nearest_time_fix_core: nearest-in-time GNRMC position finder
// One log byte per cycle; the result follows the final byte through the queue, the fix selector and the converter.
// Throughput is one byte per clock, held back only while the record queue is
// full, which happens only while the result register is stalled.
// Reset clears the parser, queue and best fix and restores register defaults.
// ----------------------------------------------------------------------------
module nmea_rmc_nearest_time_fix_core #(
  parameter int unsigned QUEUE_DEPTH = nrmc_pkg::QueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nrmc_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [nrmc_pkg::CfgBits-1:0]    cfg_wdata_i,
  input  logic [7:0]                      text_byte_i,
  input  logic                            end_of_log_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  output logic                            found_o,
  output logic signed [30:0]              latitude_e7_o,
  output logic signed [31:0]              longitude_e7_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i
);
  import nrmc_pkg::*;

  rec_t     push_rec, head_rec;
  logic     push, q_full, head_valid, pop;
  logic     vd_valid, vd_ready;
  verdict_t vd;

  nrmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_byte_i  (text_byte_i),
    .end_of_log_i (end_of_log_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  nrmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rec_o   (head_rec)
  );

  nrmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_valid_i (head_valid),
    .rec_i       (head_rec),
    .pop_o       (pop),
    .vd_valid_o  (vd_valid),
    .vd_o        (vd),
    .vd_ready_i  (vd_ready)
  );

  nrmc_convert u_convert (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vd_valid_i     (vd_valid),
    .vd_i           (vd),
    .vd_ready_o     (vd_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .latitude_e7_o  (latitude_e7_o),
    .longitude_e7_o (longitude_e7_o)
  );

endmodule
